FILE: sv/cnb_pkg.sv
// ============================================================================
// cnb_pkg: shared constants for the constant-novelty Bloom block
// Hash constants, filter geometry, register indexes and the hash fold helpers.
// ============================================================================
`default_nettype none

package cnb_pkg;

   // default sizes, handed to the top level as parameter defaults
   localparam int NUM_SYSCALLS_DEF = 1024;
   localparam int NUM_ARMS_DEF     = 4;

   // hash multipliers
   localparam logic [63:0] HASH_MULT_A = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] HASH_MULT_B = 64'hbf58_476d_1ce4_e5b9;

   // filter geometry: 1024 bits per syscall, stored as 16 words of 64 bits
   localparam int INDEX_W          = 10;
   localparam int BLOOM_W          = 64;
   localparam int WORD_SEL_W       = 4;
   localparam int BIT_SEL_W        = 6;
   localparam int WORDS_PER_FILTER = 16;

   localparam int TAG_W   = 32;
   localparam int COUNT_W = 16;
   localparam int ARM_CNT_W = 64;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_WINDOWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RECORDS   = 4'd1;

   localparam logic [TAG_W-1:0]   DECAY_RESET   = 32'd8;
   localparam logic [COUNT_W-1:0] MAX_REC_RESET = 16'd256;
   localparam logic [COUNT_W-1:0] NOVEL_MAX     = 16'hFFFF;

   // operand worth hashing: at least 4 and not all-ones
   function automatic logic worth_tracking(input logic [63:0] v);
      return (v >= 64'd4) && (v != '1);
   endfunction

   // x ^= x >> 32, low 10 bits
   function automatic logic [INDEX_W-1:0] fold_a(input logic [63:0] p);
      return p[9:0] ^ p[41:32];
   endfunction

   // x ^= x >> 32; x ^= x >> 16, low 10 bits
   function automatic logic [INDEX_W-1:0] fold_b(input logic [63:0] p);
      return p[9:0] ^ p[41:32] ^ p[25:16] ^ p[57:48];
   endfunction

endpackage

`default_nettype wire

FILE: sv/cmp_constant_novelty_bloom_core.sv
// ============================================================================
// cmp_constant_novelty_bloom_core: comparison-constant novelty Bloom filter
// Per-syscall 1024-bit filters with window decay and per-arm novelty credit.
// ============================================================================
// Usage:
//  - req_* carries one comparison record per item (valid/ready). rsp_* returns
//    exactly one result item per record (valid/ready). csr_* writes
//    decay_windows (index 0) and max_records (index 1); it is always ready.
//  - A record that hashes runs a multiply, then two read-modify-writes on the
//    filter RAM; other records skip both. A trace start with a valid syscall
//    number first runs the decay check. A decay clear writes 16 words, one per
//    cycle; the multiply overlaps the clear. One record is in flight at a time.
//  - The result item becomes valid in the same cycle as the next accept
//    becomes possible.
//  - After reset the block sweeps both RAMs to zero, NUM_SYSCALLS*16 filter words
//    (16384 at default size); req_ready stays low meanwhile, csr writes work.
//  - The result sits in an output register; the next item is accepted while
//    it waits. A stalled receiver holds the block only when the following
//    result is ready to leave.
// ============================================================================
`default_nettype none

module cmp_constant_novelty_bloom_core
   import cnb_pkg::*;
#(
   parameter int NUM_SYSCALLS = NUM_SYSCALLS_DEF,
   parameter int NUM_ARMS     = NUM_ARMS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   // record input
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [9:0]            req_syscall_number,
   input  wire logic [31:0]           req_window_now,
   input  wire logic                  req_first_record,
   input  wire logic                  req_last_record,
   input  wire logic                  req_const_flag,
   input  wire logic [63:0]           req_operand_one,
   input  wire logic [63:0]           req_operand_two,
   input  wire logic                  req_explorer_caller,
   input  wire logic signed [3:0]     req_picking_arm,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_record_novel,
   output logic [15:0]                rsp_novel_so_far,
   output logic                       rsp_filter_cleared,
   output logic                       rsp_credited,
   output logic [63:0]                rsp_arm_total,
   output logic                       rsp_trace_end
);

   localparam int SYS_W       = (NUM_SYSCALLS > 1) ? $clog2(NUM_SYSCALLS) : 1;
   localparam int ARM_W       = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
   localparam int BLOOM_DEPTH = NUM_SYSCALLS * WORDS_PER_FILTER;
   localparam int BLOOM_AW    = SYS_W + WORD_SEL_W;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TAG_CHK = 3'd1;
   localparam logic [2:0] S_CLEAR   = 3'd2;
   localparam logic [2:0] S_HASH    = 3'd3;
   localparam logic [2:0] S_WR_A    = 3'd4;
   localparam logic [2:0] S_WR_B    = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   // control state
   logic [2:0]            state_ff, state_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [BLOOM_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [TAG_W-1:0]      decay_ff, decay_in;
   logic [COUNT_W-1:0]    max_rec_ff, max_rec_in;
   logic [COUNT_W-1:0]    rec_cnt_ff, rec_cnt_in;
   logic [COUNT_W-1:0]    novel_cnt_ff, novel_cnt_in;
   logic                  cleared_ff, cleared_in;
   logic [ARM_CNT_W-1:0]  arm_cnt_ff [NUM_ARMS];
   logic [ARM_CNT_W-1:0]  arm_cnt_in [NUM_ARMS];
   logic                  rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [SYS_W-1:0]      sys_ff, sys_in;
   logic [TAG_W-1:0]      now_ff, now_in;
   logic                  last_ff, last_in;
   logic                  explorer_ff, explorer_in;
   logic [3:0]            arm_ff, arm_in;
   logic                  do_bloom_ff, do_bloom_in;
   logic [WORD_SEL_W-1:0] clr_word_ff, clr_word_in;
   logic [INDEX_W-1:0]    idx_a_ff, idx_a_in;
   logic [INDEX_W-1:0]    idx_b_ff, idx_b_in;
   logic [BLOOM_W-1:0]    wdata_a_ff, wdata_a_in;
   logic                  was_a_ff, was_a_in;
   logic                  novel_ff, novel_in;

   // result register
   logic                  out_novel_ff, out_novel_in;
   logic [COUNT_W-1:0]    out_so_far_ff, out_so_far_in;
   logic                  out_cleared_ff, out_cleared_in;
   logic                  out_credited_ff, out_credited_in;
   logic [ARM_CNT_W-1:0]  out_total_ff, out_total_in;
   logic                  out_end_ff, out_end_in;

   // memory ports
   logic                  tag_wr_en, tag_rd_en;
   logic [SYS_W-1:0]      tag_wr_addr, tag_rd_addr;
   logic [TAG_W-1:0]      tag_wr_data, tag_rd_data;
   logic                  bloom_wr_en, bloom_rd_en;
   logic [BLOOM_AW-1:0]   bloom_wr_addr, bloom_rd_addr;
   logic [BLOOM_W-1:0]    bloom_wr_data, bloom_rd_data;

   // hash units
   logic                  hash_start;
   logic [63:0]           hash_value;
   logic                  hash_a_busy, hash_b_busy;
   logic [63:0]           hash_a_prod, hash_b_prod;

   // item-level helpers
   logic                  req_acc;
   logic                  nr_ok;
   logic                  have_value;
   logic [COUNT_W-1:0]    rec_base;
   logic                  examined;
   logic                  tag_stale;
   logic [INDEX_W-1:0]    fold_a_idx, fold_b_idx;
   logic [BLOOM_W-1:0]    word_b_base;
   logic                  was_b;
   logic                  arm_ok, credit;
   logic [ARM_W-1:0]      arm_sel;
   logic [ARM_CNT_W-1:0]  arm_sum;
   logic                  out_free;

   // --------------------------------------------------------------------------
   // memories and hash units
   // --------------------------------------------------------------------------
   cnb_ram #(
      .WIDTH (TAG_W),
      .DEPTH (NUM_SYSCALLS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   cnb_ram #(
      .WIDTH (BLOOM_W),
      .DEPTH (BLOOM_DEPTH)
   ) u_bloom_ram (
      .clock   (clock),
      .wr_en   (bloom_wr_en),
      .wr_addr (bloom_wr_addr),
      .wr_data (bloom_wr_data),
      .rd_en   (bloom_rd_en),
      .rd_addr (bloom_rd_addr),
      .rd_data (bloom_rd_data)
   );

   cnb_hash #(
      .MULT (HASH_MULT_A)
   ) u_hash_a (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .value   (hash_value),
      .busy    (hash_a_busy),
      .product (hash_a_prod)
   );

   cnb_hash #(
      .MULT (HASH_MULT_B)
   ) u_hash_b (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .value   (hash_value),
      .busy    (hash_b_busy),
      .product (hash_b_prod)
   );

   // --------------------------------------------------------------------------
   // handshakes and item decode
   // --------------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE) && !clr_busy_ff;
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign nr_ok      = 32'(req_syscall_number) < 32'(NUM_SYSCALLS);
   assign have_value = worth_tracking(req_operand_one) || worth_tracking(req_operand_two);
   assign hash_value = worth_tracking(req_operand_one) ? req_operand_one : req_operand_two;
   assign hash_start = req_acc;
   assign rec_base   = req_first_record ? '0 : rec_cnt_ff;
   assign examined   = rec_base < max_rec_ff;

   assign tag_stale  = (now_ff - tag_rd_data) > decay_ff;
   assign fold_a_idx = fold_a(hash_a_prod);
   assign fold_b_idx = fold_b(hash_b_prod);

   // second word: forward the first write when both hashes hit one word
   assign word_b_base = (idx_b_ff[INDEX_W-1:BIT_SEL_W] == idx_a_ff[INDEX_W-1:BIT_SEL_W])
                        ? wdata_a_ff : bloom_rd_data;
   assign was_b       = !word_b_base[idx_b_ff[BIT_SEL_W-1:0]];

   // arm credit
   assign arm_ok  = !arm_ff[3] && (32'(arm_ff[2:0]) < 32'(NUM_ARMS));
   assign credit  = last_ff && (novel_cnt_ff != '0) && !explorer_ff && arm_ok;
   assign arm_sel = arm_ff[ARM_W-1:0];
   assign arm_sum = arm_cnt_ff[arm_sel] + ARM_CNT_W'(novel_cnt_ff);

   // --------------------------------------------------------------------------
   // memory port control
   // --------------------------------------------------------------------------
   always_comb begin
      tag_wr_en     = 1'b0;
      tag_wr_addr   = sys_ff;
      tag_wr_data   = now_ff;
      tag_rd_en     = req_acc;
      tag_rd_addr   = SYS_W'(req_syscall_number);
      bloom_wr_en   = 1'b0;
      bloom_wr_addr = {sys_ff, clr_word_ff};
      bloom_wr_data = '0;
      bloom_rd_en   = 1'b0;
      bloom_rd_addr = {sys_ff, fold_a_idx[INDEX_W-1:BIT_SEL_W]};
      if (clr_busy_ff) begin
         // power-up sweep of both RAMs
         tag_wr_en     = 1'b1;
         tag_wr_addr   = clr_addr_ff[BLOOM_AW-1:WORD_SEL_W];
         tag_wr_data   = '0;
         bloom_wr_en   = 1'b1;
         bloom_wr_addr = clr_addr_ff;
      end else begin
         case (state_ff)
            S_TAG_CHK: tag_wr_en = tag_stale;
            S_CLEAR:   bloom_wr_en = 1'b1;
            S_HASH:    bloom_rd_en = !hash_a_busy && !hash_b_busy;
            S_WR_A: begin
               bloom_wr_en   = 1'b1;
               bloom_wr_addr = {sys_ff, idx_a_ff[INDEX_W-1:BIT_SEL_W]};
               bloom_wr_data = bloom_rd_data
                               | (BLOOM_W'(1) << idx_a_ff[BIT_SEL_W-1:0]);
               bloom_rd_en   = 1'b1;
               bloom_rd_addr = {sys_ff, idx_b_ff[INDEX_W-1:BIT_SEL_W]};
            end
            S_WR_B: begin
               bloom_wr_en   = 1'b1;
               bloom_wr_addr = {sys_ff, idx_b_ff[INDEX_W-1:BIT_SEL_W]};
               bloom_wr_data = word_b_base
                               | (BLOOM_W'(1) << idx_b_ff[BIT_SEL_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // sequencer and next-state logic
   // --------------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      clr_busy_in     = clr_busy_ff;
      clr_addr_in     = clr_addr_ff;
      decay_in        = decay_ff;
      max_rec_in      = max_rec_ff;
      rec_cnt_in      = rec_cnt_ff;
      novel_cnt_in    = novel_cnt_ff;
      cleared_in      = cleared_ff;
      arm_cnt_in      = arm_cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      sys_in          = sys_ff;
      now_in          = now_ff;
      last_in         = last_ff;
      explorer_in     = explorer_ff;
      arm_in          = arm_ff;
      do_bloom_in     = do_bloom_ff;
      clr_word_in     = clr_word_ff;
      idx_a_in        = idx_a_ff;
      idx_b_in        = idx_b_ff;
      wdata_a_in      = wdata_a_ff;
      was_a_in        = was_a_ff;
      novel_in        = novel_ff;
      out_novel_in    = out_novel_ff;
      out_so_far_in   = out_so_far_ff;
      out_cleared_in  = out_cleared_ff;
      out_credited_in = out_credited_ff;
      out_total_in    = out_total_ff;
      out_end_in      = out_end_ff;

      // power-up sweep
      if (clr_busy_ff) begin
         if (clr_addr_ff == BLOOM_AW'(BLOOM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end

      // configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DECAY_WINDOWS: decay_in   = csr_data[TAG_W-1:0];
            CSR_MAX_RECORDS:   max_rec_in = csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end

      // output register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               sys_in      = SYS_W'(req_syscall_number);
               now_in      = req_window_now;
               last_in     = req_last_record;
               explorer_in = req_explorer_caller;
               arm_in      = req_picking_arm;
               novel_in    = 1'b0;
               do_bloom_in = examined && nr_ok && req_const_flag && have_value;
               rec_cnt_in  = examined ? rec_base + 1'b1 : rec_base;
               if (req_first_record) begin
                  novel_cnt_in = '0;
                  cleared_in   = 1'b0;
               end
               if (req_first_record && nr_ok) begin
                  state_in = S_TAG_CHK;
               end else if (examined && nr_ok && req_const_flag && have_value) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_TAG_CHK: begin
            clr_word_in = '0;
            if (tag_stale) begin
               cleared_in = 1'b1;
               state_in   = S_CLEAR;
            end else begin
               state_in = do_bloom_ff ? S_HASH : S_DONE;
            end
         end
         S_CLEAR: begin
            clr_word_in = clr_word_ff + 1'b1;
            if (clr_word_ff == WORD_SEL_W'(WORDS_PER_FILTER - 1)) begin
               state_in = do_bloom_ff ? S_HASH : S_DONE;
            end
         end
         S_HASH: begin
            if (!hash_a_busy && !hash_b_busy) begin
               idx_a_in = fold_a_idx;
               idx_b_in = fold_b_idx;
               state_in = S_WR_A;
            end
         end
         S_WR_A: begin
            wdata_a_in = bloom_wr_data;
            was_a_in   = !bloom_rd_data[idx_a_ff[BIT_SEL_W-1:0]];
            state_in   = S_WR_B;
         end
         S_WR_B: begin
            novel_in = was_a_ff || was_b;
            if ((was_a_ff || was_b) && (novel_cnt_ff != NOVEL_MAX)) begin
               novel_cnt_in = novel_cnt_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               out_novel_in    = novel_ff;
               out_so_far_in   = novel_cnt_ff;
               out_cleared_in  = cleared_ff;
               out_credited_in = credit;
               out_total_in    = credit ? arm_sum : '0;
               out_end_in      = last_ff;
               if (credit) begin
                  arm_cnt_in[arm_sel] = arm_sum;
               end
               if (last_ff) begin
                  rec_cnt_in   = '0;
                  novel_cnt_in = '0;
                  cleared_in   = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         decay_ff     <= DECAY_RESET;
         max_rec_ff   <= MAX_REC_RESET;
         rec_cnt_ff   <= '0;
         novel_cnt_ff <= '0;
         cleared_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ARMS; i++) begin
            arm_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         decay_ff     <= decay_in;
         max_rec_ff   <= max_rec_in;
         rec_cnt_ff   <= rec_cnt_in;
         novel_cnt_ff <= novel_cnt_in;
         cleared_ff   <= cleared_in;
         rsp_valid_ff <= rsp_valid_in;
         arm_cnt_ff   <= arm_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sys_ff          <= sys_in;
      now_ff          <= now_in;
      last_ff         <= last_in;
      explorer_ff     <= explorer_in;
      arm_ff          <= arm_in;
      do_bloom_ff     <= do_bloom_in;
      clr_word_ff     <= clr_word_in;
      idx_a_ff        <= idx_a_in;
      idx_b_ff        <= idx_b_in;
      wdata_a_ff      <= wdata_a_in;
      was_a_ff        <= was_a_in;
      novel_ff        <= novel_in;
      out_novel_ff    <= out_novel_in;
      out_so_far_ff   <= out_so_far_in;
      out_cleared_ff  <= out_cleared_in;
      out_credited_ff <= out_credited_in;
      out_total_ff    <= out_total_in;
      out_end_ff      <= out_end_in;
   end

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_novel   = out_novel_ff;
   assign rsp_novel_so_far   = out_so_far_ff;
   assign rsp_filter_cleared = out_cleared_ff;
   assign rsp_credited       = out_credited_ff;
   assign rsp_arm_total      = out_total_ff;
   assign rsp_trace_end      = out_end_ff;

   // --------------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------------
   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !(req_valid && req_ready))
      else $error("item accepted while previous item still in flight");

   // second filter write always follows the first
   a_wr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR_B) |-> ($past(state_ff) == S_WR_A))
      else $error("second filter write without first");

   // a credited item ends a trace with a nonzero count
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_credited) |-> (rsp_trace_end && (rsp_novel_so_far != '0)))
      else $error("credit without trace end or novel records");

   // a novel record is counted
   a_novel_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_novel) |-> (rsp_novel_so_far != '0))
      else $error("novel record with zero trace count");

   // no filter access while the power-up sweep runs
   a_sweep: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (state_ff == S_IDLE))
      else $error("item processing during RAM sweep");

endmodule

`default_nettype wire

FILE: sv/cnb_ram.sv
// ============================================================================
// cnb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module cnb_ram #(
   parameter  int WIDTH = 64,
   parameter  int DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/cnb_hash.sv
// ============================================================================
// cnb_hash: 64x64 multiply by a constant, low 64 bits of the product
// One 32x32 multiplier, three partial products.
// ============================================================================
`default_nettype none

module cnb_hash
   import cnb_pkg::*;
#(
   parameter logic [63:0] MULT = HASH_MULT_A
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             busy,
   output logic      [63:0] product
);

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] value_ff, value_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_x, mul_y;

   // partial product select: lo*lo, hi*lo, lo*hi
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_x = value_ff[31:0];
            mul_y = MULT[31:0];
         end
         2'd1: begin
            mul_x = value_ff[63:32];
            mul_y = MULT[31:0];
         end
         default: begin
            mul_x = value_ff[31:0];
            mul_y = MULT[63:32];
         end
      endcase
   end

   // step sequencer and accumulate
   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      value_in = value_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 2'd0;
         value_in = value;
      end else if (busy_ff) begin
         prod_in = 64'(mul_x) * 64'(mul_y);
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: ;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
            default: begin
               acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               busy_in       = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: sim/cmp_constant_novelty_bloom_core_test.sv
// ============================================================================
// cmp_constant_novelty_bloom_core_test: self-checking bench for the novelty core
// Drives comparison records through valid/ready with random idling on both
// sides. An in-bench predictor keeps its own Bloom filters, window tags and
// arm counters, and each result item is checked field by field, in order.
// ============================================================================
module cmp_constant_novelty_bloom_core_test
   import cnb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SYSCALL_COUNT  = 1024;
   localparam int ARM_COUNT      = 4;
   localparam int OPERAND_POOL   = 24;
   localparam int HOT_SYSCALLS   = 6;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int PRINT_CAP      = 100;

   localparam logic [63:0] MUL_HASH_A = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_HASH_B = 64'hbf58476d1ce4e5b9;

   typedef struct {
      logic [9:0]        nr;
      logic [31:0]       window;
      logic              first_rec;
      logic              last_rec;
      logic              is_const;
      logic [63:0]       op1;
      logic [63:0]       op2;
      logic              explorer;
      logic signed [3:0] arm;
   } cmp_record_type;

   typedef struct {
      logic        novel;
      logic [15:0] novel_so_far;
      logic        cleared;
      logic        credited;
      logic [63:0] arm_total;
      logic        trace_end;
   } novelty_result_type;

   // DUT ports, known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DECAY_WINDOWS;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [9:0]            req_syscall_number = '0;
   logic [31:0]           req_window_now = '0;
   logic                  req_first_record = 1'b0;
   logic                  req_last_record = 1'b0;
   logic                  req_const_flag = 1'b0;
   logic [63:0]           req_operand_one = '0;
   logic [63:0]           req_operand_two = '0;
   logic                  req_explorer_caller = 1'b0;
   logic signed [3:0]     req_picking_arm = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_record_novel;
   logic [15:0]           rsp_novel_so_far;
   logic                  rsp_filter_cleared;
   logic                  rsp_credited;
   logic [63:0]           rsp_arm_total;
   logic                  rsp_trace_end;

   cmp_constant_novelty_bloom_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_syscall_number  (req_syscall_number),
      .req_window_now      (req_window_now),
      .req_first_record    (req_first_record),
      .req_last_record     (req_last_record),
      .req_const_flag      (req_const_flag),
      .req_operand_one     (req_operand_one),
      .req_operand_two     (req_operand_two),
      .req_explorer_caller (req_explorer_caller),
      .req_picking_arm     (req_picking_arm),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_record_novel    (rsp_record_novel),
      .rsp_novel_so_far    (rsp_novel_so_far),
      .rsp_filter_cleared  (rsp_filter_cleared),
      .rsp_credited        (rsp_credited),
      .rsp_arm_total       (rsp_arm_total),
      .rsp_trace_end       (rsp_trace_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   bit [1023:0] bloom_bits [SYSCALL_COUNT];
   bit [31:0]   filter_tags [SYSCALL_COUNT];
   bit [63:0]   arm_novelty [ARM_COUNT];
   bit [15:0]   trace_novel;
   bit [15:0]   trace_records;
   bit          trace_cleared;
   bit [31:0]   decay_cfg = 32'd8;
   bit [15:0]   max_records_cfg = 16'd256;

   novelty_result_type due_results [$];

   // stimulus pools and bookkeeping
   logic [63:0] operand_pool [OPERAND_POOL];
   logic [9:0]  hot_syscall [HOT_SYSCALLS];
   logic [31:0] window_now = '0;
   bit          calm = 1'b0;
   int unsigned errors = 0;
   int unsigned records_sent = 0;
   int unsigned results_checked = 0;
   int unsigned clears_seen = 0;
   int unsigned credits_seen = 0;
   int unsigned novel_seen = 0;
   int unsigned drains = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_hold = 0;

   function automatic bit [9:0] hash_first(input bit [63:0] v);
      bit [63:0] x;
      x = v * MUL_HASH_A;
      x ^= x >> 32;
      return x[9:0];
   endfunction

   function automatic bit [9:0] hash_second(input bit [63:0] v);
      bit [63:0] x;
      x = v * MUL_HASH_B;
      x ^= x >> 32;
      x ^= x >> 16;
      return x[9:0];
   endfunction

   function automatic bit hashable(input bit [63:0] v);
      return (v >= 64'd4) && (v != '1);
   endfunction

   // advance the predictor by one record and form its result
   task automatic predict_novelty(input cmp_record_type r, output novelty_result_type e);
      bit [31:0] lag;
      bit [63:0] picked;
      bit        have;
      bit [9:0]  ia;
      bit [9:0]  ib;
      bit        clear_a;
      bit        clear_b;
      int        arm_i;
      e = '{default: 0};
      arm_i = r.arm;
      if (r.first_rec) begin
         trace_novel = '0;
         trace_records = '0;
         trace_cleared = 1'b0;
         lag = r.window - filter_tags[r.nr];
         if (int'(r.nr) < SYSCALL_COUNT && lag > decay_cfg) begin
            filter_tags[r.nr] = r.window;
            bloom_bits[r.nr] = '0;
            trace_cleared = 1'b1;
            clears_seen++;
         end
      end
      // only the first max_records records of a trace touch the filter
      if (trace_records < max_records_cfg) begin
         trace_records++;
         if (int'(r.nr) < SYSCALL_COUNT && r.is_const) begin
            have = 1'b1;
            if (hashable(r.op1)) picked = r.op1;
            else if (hashable(r.op2)) picked = r.op2;
            else have = 1'b0;
            if (have) begin
               ia = hash_first(picked);
               ib = hash_second(picked);
               clear_a = !bloom_bits[r.nr][ia];
               bloom_bits[r.nr][ia] = 1'b1;
               clear_b = !bloom_bits[r.nr][ib];
               bloom_bits[r.nr][ib] = 1'b1;
               e.novel = clear_a || clear_b;
               if (e.novel) novel_seen++;
               if (e.novel && trace_novel != 16'hFFFF) trace_novel++;
            end
         end
      end
      if (r.last_rec && trace_novel != 0 && !r.explorer && arm_i >= 0 && arm_i < ARM_COUNT)
      begin
         arm_novelty[arm_i] += 64'(trace_novel);
         e.arm_total = arm_novelty[arm_i];
         e.credited = 1'b1;
         credits_seen++;
      end
      e.novel_so_far = trace_novel;
      e.cleared = trace_cleared;
      e.trace_end = r.last_rec;
      if (r.last_rec) begin
         trace_novel = '0;
         trace_records = '0;
         trace_cleared = 1'b0;
      end
   endtask

   // present one item, hold it until accepted, then queue its prediction
   task automatic send_record(input cmp_record_type r);
      novelty_result_type e;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_syscall_number  <= r.nr;
      req_window_now      <= r.window;
      req_first_record    <= r.first_rec;
      req_last_record     <= r.last_rec;
      req_const_flag      <= r.is_const;
      req_operand_one     <= r.op1;
      req_operand_two     <= r.op2;
      req_explorer_caller <= r.explorer;
      req_picking_arm     <= r.arm;
      do @(posedge clock); while (!req_ready);
      predict_novelty(r, e);
      due_results.push_back(e);
      records_sent++;
   endtask

   // sender holds off until every queued result has been checked
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      drains++;
   endtask

   // both registers back to back; only called with the core idle
   task automatic write_settings(input bit [31:0] decay, input bit [15:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_DECAY_WINDOWS;
      csr_data  <= decay;
      do @(posedge clock); while (!csr_ready);
      decay_cfg = decay;
      csr_index <= CSR_MAX_RECORDS;
      csr_data  <= {16'h0, limit};
      do @(posedge clock); while (!csr_ready);
      max_records_cfg = limit;
      csr_valid <= 1'b0;
   endtask

   function automatic cmp_record_type compose_record(input logic [9:0] nr,
                                                     input logic [31:0] win,
                                                     input bit first_rec, input bit last_rec,
                                                     input bit is_const, input logic [63:0] op1,
                                                     input logic [63:0] op2, input bit explorer,
                                                     input int arm);
      cmp_record_type r;
      r.nr = nr;
      r.window = win;
      r.first_rec = first_rec;
      r.last_rec = last_rec;
      r.is_const = is_const;
      r.op1 = op1;
      r.op2 = op2;
      r.explorer = explorer;
      r.arm = arm[3:0];
      return r;
   endfunction

   // mostly reused values so filters see hits, plus edges and fresh noise
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 64'($urandom_range(0, 3));
         1:       return '1;
         2, 3:    return {$urandom, $urandom};
         4:       return $urandom_range(0, 1) ? 64'd4 : 64'hFFFF_FFFF_FFFF_FFFE;
         default: return operand_pool[$urandom_range(0, OPERAND_POOL - 1)];
      endcase
   endfunction

   // well-formed traces with random content; a few broken framings
   task automatic run_traces(input int n_items, input int max_len);
      int             sent;
      int             len;
      int             arm_pick;
      logic [9:0]     nr;
      cmp_record_type r;
      sent = 0;
      while (sent < n_items) begin
         nr = ($urandom_range(0, 7) == 0) ? 10'($urandom) :
              hot_syscall[$urandom_range(0, HOT_SYSCALLS - 1)];
         if ($urandom_range(0, 15) == 0) window_now = $urandom;
         else window_now += 32'($urandom_range(0, 4));
         len = $urandom_range(1, max_len);
         for (int k = 0; k < len; k++) begin
            arm_pick = int'($urandom_range(0, 8)) - 1;
            r = compose_record(($urandom_range(0, 19) == 0) ? 10'($urandom) : nr,
                               window_now, k == 0, k == len - 1,
                               $urandom_range(0, 7) != 0, pick_operand(), pick_operand(),
                               $urandom_range(0, 7) == 0, arm_pick);
            if ($urandom_range(0, 11) == 0) begin
               r.first_rec = $urandom_range(0, 1);
               r.last_rec  = $urandom_range(0, 1);
            end
            send_record(r);
            sent++;
         end
         if ($urandom_range(0, 29) == 0) wait_all_results();
      end
   endtask

   // reset settings: operand choice, boring values, crediting rules, decay wrap
   task automatic test_directed_defaults();
      send_record(compose_record(10'd0, 32'd0, 1, 0, 1, 64'd4, 64'd0, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 0, 1, 64'd4, 64'd0, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 0, 1, 64'd3, 64'd5, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 0, 1, '1, '1, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 0, 1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 0, 0, 64'h1234_5678_9ABC_DEF0, 64'd0, 0, 0));
      send_record(compose_record(10'd0, 32'd0, 0, 1, 1, '1, 64'hDEAD_BEEF_0BAD_F00D, 0, 0));
      // lag past threshold clears, explorer gets no credit
      send_record(compose_record(10'd1023, 32'd9, 1, 0, 1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 3));
      send_record(compose_record(10'd1023, 32'd9, 0, 1, 1, 64'h8000_0000_0000_0000, 0, 1, 3));
      // window wrap: far ahead clears, then a small modular lag does not
      send_record(compose_record(10'd5, 32'hFFFF_FFFF, 1, 1, 1, 64'h5555_5555_5555_5555, 0, 0,
                                 -1));
      send_record(compose_record(10'd5, 32'd3, 1, 1, 1, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 7));
      send_record(compose_record(10'd5, 32'd3, 1, 1, 1, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 3));
      send_record(compose_record(10'd5, 32'd3, 1, 1, 1, 64'hCAFE_0000_1234_0001, 0, 0, 3));
      wait_all_results();
      // lag equal to threshold keeps the filter; second credit to arm 0
      send_record(compose_record(10'd0, 32'd8, 1, 0, 1, 64'd4, 0, 0, 2));
      send_record(compose_record(10'd0, 32'd8, 0, 0, 1, 64'hFFFF_0000_FFFF_0000, 0, 0, 2));
      send_record(compose_record(10'd0, 32'd8, 0, 1, 1, 64'h0F0F_0F0F_0F0F_0F0F, 0, 0, 0));
      // records with no trace start
      send_record(compose_record(10'd512, 32'd100, 0, 0, 1, 64'h0123_4567_89AB_CDEF, 0, 0, 1));
      send_record(compose_record(10'd512, 32'd100, 0, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1));
      send_record(compose_record(10'd0, 32'd17, 1, 1, 1, 64'd4, 0, 0, 2));
      send_record(compose_record(10'd1023, 32'd0, 1, 0, 1, 64'd6, 0, 0, 1));
      send_record(compose_record(10'd1023, 32'd0, 1, 1, 0, 64'd6, 0, 0, 1));
   endtask

   // one record per trace examined, decay on any window change
   task automatic test_record_limit();
      wait_all_results();
      write_settings(32'd0, 16'd1);
      send_record(compose_record(10'd7, 32'd50, 1, 0, 1, 64'h1111_2222_3333_4444, 0, 0, 1));
      send_record(compose_record(10'd7, 32'd50, 0, 0, 1, 64'h5555_6666_7777_8888, 0, 0, 1));
      send_record(compose_record(10'd7, 32'd50, 0, 0, 1, 64'h9999_AAAA_BBBB_CCCC, 0, 0, 1));
      send_record(compose_record(10'd7, 32'd50, 0, 1, 1, 64'hDDDD_EEEE_FFFF_0001, 0, 0, 1));
      run_traces(150, 6);
   endtask

   // largest settings: decay never fires, record limit never reached
   task automatic test_decay_never();
      wait_all_results();
      write_settings(32'hFFFF_FFFF, 16'hFFFF);
      run_traces(220, 14);
   endtask

   task automatic test_random_settings();
      wait_all_results();
      write_settings(32'($urandom_range(0, 12)), 16'($urandom_range(2, 8)));
      run_traces(200, 12);
      wait_all_results();
      write_settings($urandom, 16'($urandom_range(1, 65535)));
      run_traces(200, 12);
   endtask

   // closing stretch with no idling on either side
   task automatic test_quiet_tail();
      wait_all_results();
      calm = 1'b1;
      write_settings(32'd3, 16'd5);
      run_traces(250, 8);
   endtask

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
   endtask

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (!calm && rsp_hold == 0 && $urandom_range(0, 5) == 0)
         rsp_hold = $urandom_range(1, 14);
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker: oldest prediction against each accepted result item
   always @(posedge clock) begin
      novelty_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result item with nothing expected, expected none, actual novel=%0b",
                     $time, rsp_record_novel);
         end else begin
            want = due_results.pop_front();
            results_checked++;
            check_field("record_novel", want.novel, rsp_record_novel);
            check_field("novel_so_far", want.novel_so_far, rsp_novel_so_far);
            check_field("filter_cleared", want.cleared, rsp_filter_cleared);
            check_field("credited", want.credited, rsp_credited);
            check_field("arm_total", want.arm_total, rsp_arm_total);
            check_field("trace_end", want.trace_end, rsp_trace_end);
         end
      end
   end

   // watchdog on cycles with no item moving on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, due_results.size());
         $display("cmp_constant_novelty_bloom_core verification failed");
         $finish;
      end
   end

   initial begin
      foreach (operand_pool[i]) operand_pool[i] = {$urandom, $urandom};
      hot_syscall[0] = 10'd0;
      hot_syscall[1] = 10'd1023;
      for (int i = 2; i < HOT_SYSCALLS; i++) hot_syscall[i] = 10'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_record_limit();
      test_decay_never();
      test_random_settings();
      test_quiet_tail();

      wait_all_results();
      repeat (40) @(posedge clock);
      $display("ran %0d records, checked %0d results: %0d filter clears, %0d credits, %0d novel",
               records_sent, results_checked, clears_seen, credits_seen, novel_seen);
      $display("record limits 1 to 65535, decay 0 to max, %0d full drains, idling on and off",
               drains);
      if (errors == 0) begin
         $display("cmp_constant_novelty_bloom_core verification clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("cmp_constant_novelty_bloom_core verification failed");
      end
      $finish;
   end

endmodule
